// ===== src/aprhs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aprhs_pkg
// Types, widths and register codes shared by the cardiac RHS datapath.
// ----------------------------------------------------------------------------
package aprhs_pkg;

  // data word width (signed, 16 fraction bits)
  localparam int DataWidth = 24;
  localparam int FracBits  = 16;
  localparam int CfgWidth  = 23;

  // configuration port
  localparam int AddrWidth = 5;
  localparam int BusWidth  = 32;

  localparam logic [2:0] RegMu1        = 3'd0;
  localparam logic [2:0] RegMu2        = 3'd1;
  localparam logic [2:0] RegGainK      = 3'd2;
  localparam logic [2:0] RegThresholdA = 3'd3;
  localparam logic [2:0] RegEpsilon    = 3'd4;

  localparam logic [CfgWidth-1:0] Mu1Reset        = 23'd7864;
  localparam logic [CfgWidth-1:0] Mu2Reset        = 23'd19661;
  localparam logic [CfgWidth-1:0] GainKReset      = 23'd524288;
  localparam logic [CfgWidth-1:0] ThresholdAReset = 23'd6554;
  localparam logic [CfgWidth-1:0] EpsilonReset    = 23'd655;

  // intermediate widths, all signed unless noted
  localparam int MaxVC   = (DataWidth > CfgWidth + 1) ? DataWidth : CfgWidth + 1;
  localparam int KvW     = DataWidth + CfgWidth + 1;        // k*v, mu1*r
  localparam int T1W     = KvW - FracBits;                  // t1, q
  localparam int VrW     = 2 * DataWidth - FracBits;        // rnd(v*r)
  localparam int VaW     = MaxVC + 2;                       // v-a, v-a-1, v-1
  localparam int M2W     = T1W + VaW;
  localparam int T2W     = M2W - FracBits;
  localparam int HW      = T2W + 1;                         // h
  localparam int M3W     = T2W + VaW;
  localparam int T3W     = M3W - FracBits;
  localparam int DvW     = T3W + 2;                         // unsaturated dV
  localparam int DenW    = ((DataWidth - 1 > CfgWidth) ? DataWidth - 1 : CfgWidth) + 2;
  localparam int DMagW   = DenW - 1;                        // |den|, unsigned
  localparam int QMagW   = T1W - 1;                         // |q|, unsigned
  localparam int NumW    = QMagW + FracBits;                // dividend, quotient bits
  localparam int FW      = NumW + 1;                        // signed quotient
  localparam int GW      = FW + 1;                          // g
  localparam int GLoW    = GW / 2;
  localparam int PLoW    = GLoW + 1 + HW;
  localparam int PHiW    = GW - GLoW + HW;
  localparam int PW      = GW + HW;                         // g*h
  localparam int DrW     = PW - FracBits + 1;               // unsaturated dr

  typedef struct packed {
    logic [CfgWidth-1:0] mu1;
    logic [CfgWidth-1:0] mu2;
    logic [CfgWidth-1:0] gain_k;
    logic [CfgWidth-1:0] threshold_a;
    logic [CfgWidth-1:0] epsilon;
  } cfg_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] potential;
    logic signed [DataWidth-1:0] recovery;
  } in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] potential_rate;
    logic signed [DataWidth-1:0] recovery_rate;
    logic                        overflow;
    logic                        divide_fault;
  } out_t;

  // one slot of the divider chain
  typedef struct packed {
    logic             vld;
    logic             fault;
    logic             qneg;
    logic [DMagW-1:0] dmag;
    logic [DMagW-1:0] rem;
    logic [NumW-1:0]  num;
  } div_t;

  // V-path results riding alongside the divider
  typedef struct packed {
    logic signed [DataWidth-1:0] dv;
    logic                        ovf;
    logic signed [HW-1:0]        h;
  } side_t;

endpackage

// ===== src/aprhs_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aprhs_cfg
// APB register bank holding the five model coefficients.
// ----------------------------------------------------------------------------
module aprhs_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [aprhs_pkg::AddrWidth-1:0]    paddr,
  input  logic [aprhs_pkg::BusWidth-1:0]     pwdata,
  output logic [aprhs_pkg::BusWidth-1:0]     prdata,
  output logic                               pready,
  output aprhs_pkg::cfg_t                    cfg_o
);

  aprhs_pkg::cfg_t cfg_q;
  logic [2:0] idx;
  logic       wr;
  logic [aprhs_pkg::CfgWidth-1:0] wval;
  logic [aprhs_pkg::CfgWidth-1:0] rval;

  assign idx  = paddr[aprhs_pkg::AddrWidth-1:2];
  assign wr   = psel & penable & pwrite;
  assign wval = pwdata[aprhs_pkg::CfgWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mu1         <= aprhs_pkg::Mu1Reset;
      cfg_q.mu2         <= aprhs_pkg::Mu2Reset;
      cfg_q.gain_k      <= aprhs_pkg::GainKReset;
      cfg_q.threshold_a <= aprhs_pkg::ThresholdAReset;
      cfg_q.epsilon     <= aprhs_pkg::EpsilonReset;
    end else if (wr) begin
      case (idx)
        aprhs_pkg::RegMu1:        cfg_q.mu1         <= wval;
        aprhs_pkg::RegMu2:        cfg_q.mu2         <= wval;
        aprhs_pkg::RegGainK:      cfg_q.gain_k      <= wval;
        aprhs_pkg::RegThresholdA: cfg_q.threshold_a <= wval;
        aprhs_pkg::RegEpsilon:    cfg_q.epsilon     <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      aprhs_pkg::RegMu1:        rval = cfg_q.mu1;
      aprhs_pkg::RegMu2:        rval = cfg_q.mu2;
      aprhs_pkg::RegGainK:      rval = cfg_q.gain_k;
      aprhs_pkg::RegThresholdA: rval = cfg_q.threshold_a;
      aprhs_pkg::RegEpsilon:    rval = cfg_q.epsilon;
      default:                  rval = '0;
    endcase
  end

  assign prdata = {{(aprhs_pkg::BusWidth - aprhs_pkg::CfgWidth){1'b0}}, rval};
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule

// ===== src/aprhs_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aprhs_div_cell
// One restoring-division step: retires one quotient bit per cell.
// ----------------------------------------------------------------------------
module aprhs_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  aprhs_pkg::div_t cell_i,
  output aprhs_pkg::div_t cell_o
);

  localparam int DMagW = aprhs_pkg::DMagW;
  localparam int NumW  = aprhs_pkg::NumW;

  logic                vld_q;
  aprhs_pkg::div_t     data_q;
  aprhs_pkg::div_t     data_d;
  logic [DMagW+1:0]    diff;

  always_comb begin
    // trial subtract of {rem, next dividend bit}
    diff   = {1'b0, cell_i.rem, cell_i.num[NumW-1]} - {2'b00, cell_i.dmag};
    data_d = cell_i;
    if (!diff[DMagW+1]) begin
      data_d.rem = diff[DMagW-1:0];
      data_d.num = {cell_i.num[NumW-2:0], 1'b1};
    end else begin
      data_d.rem = {cell_i.rem[DMagW-2:0], cell_i.num[NumW-1]};
      data_d.num = {cell_i.num[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    cell_o     = data_q;
    cell_o.vld = vld_q;
  end

endmodule

// ===== src/aliev_panfilov_rhs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aliev_panfilov_rhs
// Aliev-Panfilov cell model right-hand side (dV, dr) for one mesh node.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                  payload
//  --------  ---  -------------------------  ----------------------------------
//  in        in   in_valid_i / in_ready_o    in_data_i  (potential, recovery)
//  out       out  out_valid_o / out_ready_i  out_data_o (rates, overflow, fault)
//  cfg       in   APB psel/penable/pwrite    5 coefficient registers, 4*i
//
//  One transaction per cycle sustained while the output is not stalled. Most
//  of the pipe is the divider: a chain of DATA_WIDTH + 23 cells,
//  one quotient bit per cell.
//  All stages advance together; a stalled output freezes the whole pipe, and
//  in_ready_o drops only while a result waits with out_ready_i low.
//  Reset clears the valid bits and restores the coefficient defaults.
//
module aliev_panfilov_rhs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  aprhs_pkg::in_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output aprhs_pkg::out_t                  out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [aprhs_pkg::AddrWidth-1:0]  paddr,
  input  logic [aprhs_pkg::BusWidth-1:0]   pwdata,
  output logic [aprhs_pkg::BusWidth-1:0]   prdata,
  output logic                             pready
);

  localparam int W     = aprhs_pkg::DataWidth;
  localparam int CW    = aprhs_pkg::CfgWidth;
  localparam int KvW   = aprhs_pkg::KvW;
  localparam int T1W   = aprhs_pkg::T1W;
  localparam int VrW   = aprhs_pkg::VrW;
  localparam int VaW   = aprhs_pkg::VaW;
  localparam int M2W   = aprhs_pkg::M2W;
  localparam int T2W   = aprhs_pkg::T2W;
  localparam int HW    = aprhs_pkg::HW;
  localparam int M3W   = aprhs_pkg::M3W;
  localparam int T3W   = aprhs_pkg::T3W;
  localparam int DvW   = aprhs_pkg::DvW;
  localparam int DenW  = aprhs_pkg::DenW;
  localparam int DMagW = aprhs_pkg::DMagW;
  localparam int QMagW = aprhs_pkg::QMagW;
  localparam int NumW  = aprhs_pkg::NumW;
  localparam int FW    = aprhs_pkg::FW;
  localparam int GW    = aprhs_pkg::GW;
  localparam int GLoW  = aprhs_pkg::GLoW;
  localparam int PLoW  = aprhs_pkg::PLoW;
  localparam int PHiW  = aprhs_pkg::PHiW;
  localparam int PW    = aprhs_pkg::PW;
  localparam int DrW   = aprhs_pkg::DrW;
  localparam int FB    = aprhs_pkg::FracBits;
  localparam int SideN = NumW - 3;   // aligns V path with the last divider cell

  aprhs_pkg::cfg_t cfg;

  aprhs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // global advance: move when the output slot is empty or being drained
  logic en;
  logic out_vld_q;
  assign en          = !out_vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_vld_q;

  // ---------------- stage A: first products ----------------
  logic                    a_vld_q;
  logic signed [W-1:0]     a_v_q, a_r_q;
  logic signed [KvW-1:0]   a_kv_q, a_mr_q;
  logic signed [2*W-1:0]   a_vr_q;
  logic signed [DenW-1:0]  a_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_v_q   <= in_data_i.potential;
      a_r_q   <= in_data_i.recovery;
      a_kv_q  <= $signed({1'b0, cfg.gain_k}) * in_data_i.potential;
      a_mr_q  <= $signed({1'b0, cfg.mu1}) * in_data_i.recovery;
      a_vr_q  <= in_data_i.potential * in_data_i.recovery;
      a_den_q <= $signed({{(DenW - CW){1'b0}}, cfg.mu2}) + DenW'(in_data_i.potential);
    end
  end

  // ---------------- stage B: round, differences ----------------
  logic signed [KvW-1:0]   kv_rnd, mr_rnd;
  logic signed [2*W-1:0]   vr_rnd;
  logic signed [VaW-1:0]   va_d;

  // round half up: add half an LSB, drop the fraction
  assign kv_rnd = a_kv_q + KvW'(32768);
  assign mr_rnd = a_mr_q + KvW'(32768);
  assign vr_rnd = a_vr_q + (2*W)'(32768);
  assign va_d   = VaW'(a_v_q) - VaW'($signed({1'b0, cfg.threshold_a}));

  logic                    b_vld_q;
  logic signed [T1W-1:0]   b_t1_q, b_q_q;
  logic signed [VrW-1:0]   b_vr_q;
  logic signed [VaW-1:0]   b_va_q, b_va1_q, b_vm1_q;
  logic signed [W-1:0]     b_r_q;
  logic signed [DenW-1:0]  b_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_t1_q  <= kv_rnd[KvW-1:FB];
      b_q_q   <= mr_rnd[KvW-1:FB];
      b_vr_q  <= vr_rnd[2*W-1:FB];
      b_va_q  <= va_d;
      b_va1_q <= va_d - VaW'(65536);
      b_vm1_q <= VaW'(a_v_q) - VaW'(65536);
      b_r_q   <= a_r_q;
      b_den_q <= a_den_q;
    end
  end

  // ---------------- divider chain: f = trunc(q*2^16 / den) ----------------
  logic [T1W-1:0]   q_abs;
  logic [DenW-1:0]  den_abs;
  aprhs_pkg::div_t  chain [NumW+1];

  assign q_abs   = b_q_q[T1W-1] ? T1W'(-b_q_q) : T1W'(b_q_q);
  assign den_abs = b_den_q[DenW-1] ? DenW'(-b_den_q) : DenW'(b_den_q);

  always_comb begin
    chain[0].vld   = b_vld_q;
    chain[0].fault = (b_den_q == '0);
    chain[0].qneg  = b_q_q[T1W-1] ^ b_den_q[DenW-1];
    chain[0].dmag  = den_abs[DMagW-1:0];
    chain[0].rem   = '0;
    chain[0].num   = {q_abs[QMagW-1:0], {FB{1'b0}}};
  end

  for (genvar gi = 0; gi < NumW; gi++) begin : g_div
    aprhs_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[gi]),
      .cell_o (chain[gi+1])
    );
  end

  // ---------------- stage C: second products ----------------
  logic signed [M2W-1:0]  c_m2_q, c_m4_q;
  logic signed [VrW-1:0]  c_vr_q;
  logic signed [VaW-1:0]  c_vm1_q;
  logic signed [W-1:0]    c_r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_m2_q  <= b_t1_q * b_va_q;
      c_m4_q  <= b_t1_q * b_va1_q;
      c_vr_q  <= b_vr_q;
      c_vm1_q <= b_vm1_q;
      c_r_q   <= b_r_q;
    end
  end

  // ---------------- stage D: t2 and h ----------------
  logic signed [M2W-1:0]  m2_rnd, m4_rnd;
  logic signed [T2W-1:0]  m4_t;
  assign m2_rnd = c_m2_q + M2W'(32768);
  assign m4_rnd = c_m4_q + M2W'(32768);
  assign m4_t   = m4_rnd[M2W-1:FB];

  logic signed [T2W-1:0]  d_t2_q;
  logic signed [HW-1:0]   d_h_q;
  logic signed [VrW-1:0]  d_vr_q;
  logic signed [VaW-1:0]  d_vm1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_t2_q  <= m2_rnd[M2W-1:FB];
      d_h_q   <= HW'(c_r_q) + HW'(m4_t);
      d_vr_q  <= c_vr_q;
      d_vm1_q <= c_vm1_q;
    end
  end

  // ---------------- stage E: t3 product ----------------
  logic signed [M3W-1:0]  e_m3_q;
  logic signed [VrW-1:0]  e_vr_q;
  logic signed [HW-1:0]   e_h_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_m3_q <= d_t2_q * d_vm1_q;
      e_vr_q <= d_vr_q;
      e_h_q  <= d_h_q;
    end
  end

  // ---------------- stage F: dV, saturate, into the side line ----------------
  logic signed [M3W-1:0]  m3_rnd;
  logic signed [T3W-1:0]  t3;
  logic signed [DvW-1:0]  dv_x;
  logic                   dv_ok;
  aprhs_pkg::side_t       side_d;
  aprhs_pkg::side_t       side_q [SideN];

  assign m3_rnd = e_m3_q + M3W'(32768);
  assign t3     = m3_rnd[M3W-1:FB];
  assign dv_x   = -DvW'(t3) - DvW'(e_vr_q);
  // in range when all bits above the sign agree with it
  assign dv_ok  = (&dv_x[DvW-1:W-1]) | ~(|dv_x[DvW-1:W-1]);

  always_comb begin
    side_d.h   = e_h_q;
    side_d.ovf = !dv_ok;
    if (dv_ok) begin
      side_d.dv = dv_x[W-1:0];
    end else if (dv_x[DvW-1]) begin
      side_d.dv = {1'b1, {(W-1){1'b0}}};
    end else begin
      side_d.dv = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i < SideN; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // ---------------- stage G: signed quotient, g = eps + f ----------------
  aprhs_pkg::div_t        dq;
  logic signed [FW-1:0]   f_val;
  assign dq    = chain[NumW];
  assign f_val = dq.qneg ? -$signed({1'b0, dq.num}) : $signed({1'b0, dq.num});

  logic                   g_vld_q;
  logic signed [GW-1:0]   g_g_q;
  logic                   g_fault_q;
  aprhs_pkg::side_t       g_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= dq.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_g_q     <= $signed({{(GW - CW){1'b0}}, cfg.epsilon}) + GW'(f_val);
      g_fault_q <= dq.fault;
      g_side_q  <= side_q[SideN-1];
    end
  end

  // ---------------- stage M: g*h as two partial products ----------------
  logic                   m_vld_q;
  logic signed [PLoW-1:0] m_plo_q;
  logic signed [PHiW-1:0] m_phi_q;
  logic                   m_fault_q;
  aprhs_pkg::side_t       m_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_plo_q   <= $signed({1'b0, g_g_q[GLoW-1:0]}) * g_side_q.h;
      m_phi_q   <= $signed(g_g_q[GW-1:GLoW]) * g_side_q.h;
      m_fault_q <= g_fault_q;
      m_side_q  <= g_side_q;
    end
  end

  // ---------------- output stage: dr = -rnd(g*h), saturate ----------------
  logic signed [PW-1:0]   p_full, p_rnd;
  logic signed [DrW-1:0]  dr_x;
  logic                   dr_ok;
  logic signed [W-1:0]    dr_sat;
  aprhs_pkg::out_t        out_d, out_q;

  assign p_full = (PW'(m_phi_q) <<< GLoW) + PW'(m_plo_q);
  assign p_rnd  = p_full + PW'(32768);
  assign dr_x   = -DrW'($signed(p_rnd[PW-1:FB]));
  assign dr_ok  = (&dr_x[DrW-1:W-1]) | ~(|dr_x[DrW-1:W-1]);

  always_comb begin
    if (dr_ok) begin
      dr_sat = dr_x[W-1:0];
    end else if (dr_x[DrW-1]) begin
      dr_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      dr_sat = {1'b0, {(W-1){1'b1}}};
    end
    out_d.potential_rate = m_side_q.dv;
    out_d.divide_fault   = m_fault_q;
    // zero denominator: dr forced to zero, overflow from dV alone
    if (m_fault_q) begin
      out_d.recovery_rate = '0;
      out_d.overflow      = m_side_q.ovf;
    end else begin
      out_d.recovery_rate = dr_sat;
      out_d.overflow      = m_side_q.ovf | !dr_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== src/aprhs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aprhs_checker
// Port-level checks for the cardiac RHS block, bound to the top level.
// ----------------------------------------------------------------------------
module aprhs_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_o,
  input  aprhs_pkg::in_t                   in_data_i,
  input  logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  aprhs_pkg::out_t                  out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [aprhs_pkg::AddrWidth-1:0]  paddr,
  input  logic [aprhs_pkg::BusWidth-1:0]   pwdata,
  input  logic [aprhs_pkg::BusWidth-1:0]   prdata,
  input  logic                             pready
);

  // a held result keeps valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out valid dropped during stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("out payload changed during stall");

  // input backs off only while a result is stuck
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("in_ready low without output stall");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_fault |-> out_data_o.recovery_rate == '0)
    else $error("divide fault with nonzero recovery_rate");

  a_rd_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> prdata[aprhs_pkg::BusWidth-1:aprhs_pkg::CfgWidth] == '0)
    else $error("register read has bits above coefficient width");

endmodule

bind aliev_panfilov_rhs aprhs_checker u_aprhs_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Aliev-Panfilov right-hand side datapath.
// Streams node states through the block under random idling on both sides,
// computes dV/dr with the flags in a local fixed-point model, and compares
// every output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DataWidth = aprhs_pkg::DataWidth;
  localparam int CfgWidth  = aprhs_pkg::CfgWidth;
  localparam int AddrWidth = aprhs_pkg::AddrWidth;
  localparam int BusWidth  = aprhs_pkg::BusWidth;

  localparam int NumRandom  = 1600;
  localparam int WatchLimit = 20000;
  localparam int DrainWait  = 120;
  localparam int QuietTail  = 200;   // last transactions: no idling

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0, in_ready_o;
  aprhs_pkg::in_t  in_data_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  aprhs_pkg::out_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [BusWidth-1:0]  pwdata = '0;
  logic [BusWidth-1:0]  prdata;
  logic pready;

  aliev_panfilov_rhs dut (.*);

  always #10 clk_i = ~clk_i;

  // coefficient shadow of the block's registers
  logic [CfgWidth-1:0] c_mu1, c_mu2, c_k, c_a, c_eps;

  aprhs_pkg::in_t  node_q[$];     // node states waiting to be driven
  aprhs_pkg::out_t rate_q[$];     // predicted rates, oldest first
  int   mismatches = 0;
  int   quiet_cycles = 0;
  bit   hold_off = 1'b0;   // long receiver stall requested
  bit   in_taken = 1'b0;   // input transaction at the last rising edge
  int   sent = 0;

  // ---------------------------------------------------------------------------
  // fixed-point model; 128-bit signed intermediates avoid any wrap
  // ---------------------------------------------------------------------------
  function automatic logic signed [127:0] round_q16(input logic signed [127:0] x);
    return (x + 128'sd32768) >>> 16;  // floor((x + 2^15) / 2^16)
  endfunction

  function automatic aprhs_pkg::out_t predict_rates(input aprhs_pkg::in_t n);
    logic signed [127:0] v, r, k, a, one, t1, t2, t3, vr, dv, den, q, f, g, h, p, dr;
    logic signed [127:0] hi, lo;
    aprhs_pkg::out_t o;
    one = 128'sd65536;
    hi  = (128'sd1 <<< (DataWidth - 1)) - 1;
    lo  = -(128'sd1 <<< (DataWidth - 1));
    v = n.potential;
    r = n.recovery;
    k = {105'd0, c_k};
    a = {105'd0, c_a};
    o = '0;
    t1 = round_q16(k * v);
    t2 = round_q16(t1 * (v - a));
    t3 = round_q16(t2 * (v - one));
    vr = round_q16(v * r);
    dv = -t3 - vr;
    if (dv > hi) begin
      dv = hi; o.overflow = 1'b1;
    end else if (dv < lo) begin
      dv = lo; o.overflow = 1'b1;
    end
    o.potential_rate = dv[DataWidth-1:0];
    den = {105'd0, c_mu2} + v;
    if (den == 0) begin
      o.divide_fault  = 1'b1;
      o.recovery_rate = '0;
    end else begin
      q = round_q16({105'd0, c_mu1} * r);
      f = (q * one) / den;  // signed division truncates toward zero
      g = {105'd0, c_eps} + f;
      h = r + round_q16(t1 * (v - a - one));
      p = g * h;
      // |g*h| above 2^62: saturate by the sign of -(g*h)
      if (p > (128'sd1 <<< 62) || p < -(128'sd1 <<< 62)) begin
        dr = (p < 0) ? hi : lo;
        o.overflow = 1'b1;
      end else begin
        dr = -round_q16(p);
        if (dr > hi) begin
          dr = hi; o.overflow = 1'b1;
        end else if (dr < lo) begin
          dr = lo; o.overflow = 1'b1;
        end
      end
      o.recovery_rate = dr[DataWidth-1:0];
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued node states, idles in random bursts
  // ---------------------------------------------------------------------------
  int in_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        // accepted at the preceding rising edge
        if (node_q.size() != 0 && in_gap == 0) begin
          in_data_i <= node_q.pop_front();
          sent++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (node_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= node_q.pop_front();
          sent++;
          if (node_q.size() > QuietTail && $urandom_range(0, 5) == 0)
            in_gap = $urandom_range(1, 9);
        end
      end
      if (in_taken && node_q.size() > QuietTail && $urandom_range(0, 7) == 0)
        in_gap = $urandom_range(1, 9);
    end
  end

  // the prediction is made at the edge where the input transaction lands
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o)
      rate_q.push_back(predict_rates(in_data_i));
  end

  // receiver: random stall bursts, plus a long hold-off on request
  int out_gap = 0;
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else if (node_q.size() > QuietTail && $urandom_range(0, 6) == 0) begin
      out_gap = $urandom_range(1, 9);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each output transaction to the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    aprhs_pkg::out_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (rate_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output transaction %p", out_data_o);
        end else begin
          want = rate_q.pop_front();
          if (out_data_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch dV exp %0d got %0d, dr exp %0d got %0d, ovf %b/%b, div %b/%b",
                       want.potential_rate, out_data_o.potential_rate,
                       want.recovery_rate, out_data_o.recovery_rate,
                       want.overflow, out_data_o.overflow,
                       want.divide_fault, out_data_o.divide_fault);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration writes (setup then access phase), shadow updated alongside
  // ---------------------------------------------------------------------------
  task automatic write_coeff(input logic [2:0] idx, input logic [BusWidth-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AddrWidth'(idx) << 2; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      aprhs_pkg::RegMu1:        c_mu1 = val[CfgWidth-1:0];
      aprhs_pkg::RegMu2:        c_mu2 = val[CfgWidth-1:0];
      aprhs_pkg::RegGainK:      c_k   = val[CfgWidth-1:0];
      aprhs_pkg::RegThresholdA: c_a   = val[CfgWidth-1:0];
      aprhs_pkg::RegEpsilon:    c_eps = val[CfgWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic set_coeffs(input logic [BusWidth-1:0] m1, m2, k, a, e);
    write_coeff(aprhs_pkg::RegMu1, m1);
    write_coeff(aprhs_pkg::RegMu2, m2);
    write_coeff(aprhs_pkg::RegGainK, k);
    write_coeff(aprhs_pkg::RegThresholdA, a);
    write_coeff(aprhs_pkg::RegEpsilon, e);
  endtask

  // every node state has a result, so idle means queues empty
  task automatic drain_pipe();
    while (node_q.size() != 0 || in_valid_i || rate_q.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic logic signed [DataWidth-1:0] rand_word(input int mode);
    case (mode)
      0: return $signed(DataWidth'($urandom));
      1: return $signed(DataWidth'($urandom_range(0, 131072)) - DataWidth'(65536));
      default: return $signed(DataWidth'($urandom_range(0, 16383)) - DataWidth'(8192));
    endcase
  endfunction

  function automatic aprhs_pkg::in_t node(input logic signed [DataWidth-1:0] v, r);
    aprhs_pkg::in_t n;
    n.potential = v;
    n.recovery  = r;
    return n;
  endfunction

  task automatic push_random(input int count, input bit near_mu2);
    aprhs_pkg::in_t n;
    for (int i = 0; i < count; i++) begin
      n = node(rand_word($urandom_range(0, 2)), rand_word($urandom_range(0, 2)));
      // sometimes land on the zero denominator
      if (near_mu2 && $urandom_range(0, 15) == 0)
        n.potential = -$signed({1'b0, c_mu2});
      node_q.push_back(n);
    end
  endtask

  localparam logic signed [DataWidth-1:0] WMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] WMin = {1'b1, {(DataWidth-1){1'b0}}};

  initial begin
    int hold;
    c_mu1 = aprhs_pkg::Mu1Reset; c_mu2 = aprhs_pkg::Mu2Reset; c_k = aprhs_pkg::GainKReset;
    c_a = aprhs_pkg::ThresholdAReset; c_eps = aprhs_pkg::EpsilonReset;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset coefficients, field extremes, zero denominator
    node_q.push_back(node('0, '0));
    node_q.push_back(node(WMax, WMax));
    node_q.push_back(node(WMin, WMin));
    node_q.push_back(node(WMax, WMin));
    node_q.push_back(node(WMin, WMax));
    node_q.push_back(node(24'sd65536, 24'sd0));
    node_q.push_back(node(24'sd6554, 24'sd1000));
    node_q.push_back(node(-24'sd19661, 24'sd5000));
    node_q.push_back(node(-24'sd19661, WMin));
    node_q.push_back(node(24'sd1, -24'sd1));
    drain_pipe();

    // full-scale coefficients: huge quotient, saturation of both rates
    set_coeffs(32'hFFFF_FFFF, 32'd1, 32'h7F_FFFF, 32'h7F_FFFF, 32'h7F_FFFF);
    node_q.push_back(node(-24'sd1, WMax));
    node_q.push_back(node(-24'sd1, 24'sd0));
    node_q.push_back(node(WMax, WMin));
    node_q.push_back(node(24'sd3, 24'sd70000));
    push_random(200, 1'b1);
    drain_pipe();

    // all zero: mu2 = 0 makes v = 0 a divide fault
    set_coeffs(0, 0, 0, 0, 0);
    node_q.push_back(node('0, 24'sd12345));
    push_random(200, 1'b1);
    drain_pipe();

    // long receiver hold-off while the sender keeps offering
    set_coeffs($urandom_range(0, 65536), $urandom_range(1, 262143), $urandom,
               $urandom_range(0, 131072), $urandom_range(0, 4096));
    push_random(200, 1'b1);
    hold_off = 1'b1;
    hold = 0;
    while (hold < 150) begin
      @(posedge clk_i);
      hold++;
    end
    hold_off = 1'b0;
    drain_pipe();

    // back to the defaults for the long random run
    set_coeffs(aprhs_pkg::Mu1Reset, aprhs_pkg::Mu2Reset, aprhs_pkg::GainKReset,
               aprhs_pkg::ThresholdAReset, aprhs_pkg::EpsilonReset);
    push_random(NumRandom - 600, 1'b1);
    drain_pipe();

    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && rate_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== aliev_panfilov_rhs.f =====
src/aprhs_pkg.sv
src/aprhs_cfg.sv
src/aprhs_div_cell.sv
src/aliev_panfilov_rhs.sv
src/aprhs_checker.sv
test/tb_top.sv
